@@ sv/msof_pkg.sv @@
// Shared constants for the matrix scan order filler: defaults, register indexes, scan modes.
`default_nettype none

package msof_pkg;

  // Default build sizes
  localparam int unsigned MaxSideDefault   = 16;
  localparam int unsigned DataWidthDefault = 32;

  // Configuration port geometry
  localparam int unsigned CfgIndexWidth = 1;
  localparam int unsigned CfgDataWidth  = 5;
  localparam int unsigned SideRegWidth  = 5;
  localparam int unsigned ModeRegWidth  = 2;
  localparam int unsigned CoordWidth    = 4;

  // Register indexes
  localparam logic [CfgIndexWidth-1:0] REG_SIDE      = 1'd0;
  localparam logic [CfgIndexWidth-1:0] REG_SCAN_MODE = 1'd1;

  // Scan modes
  localparam logic [ModeRegWidth-1:0] MODE_DIAG        = 2'd0;
  localparam logic [ModeRegWidth-1:0] MODE_DIAG_MIRROR = 2'd1;
  localparam logic [ModeRegWidth-1:0] MODE_SPIRAL_REV  = 2'd2;
  localparam logic [ModeRegWidth-1:0] MODE_SPIRAL      = 2'd3;

  // Reset values of the registers
  localparam logic [SideRegWidth-1:0] SideReset = 5'd4;
  localparam logic [ModeRegWidth-1:0] ModeReset = MODE_DIAG;

endpackage

`default_nettype wire

@@ sv/matrix_scan_order_filler_core.sv @@
// Scan address generator that names the matrix cell for each streamed value.
`default_nettype none

// Each accepted item gets the row and column of a side x side matrix cell in the
// configured scan order (anti-diagonal, mirrored anti-diagonal, clockwise spiral,
// or that spiral walked from its end back to the top-left corner), plus a flag on
// the item that fills the final cell; the walk then starts over. The block takes
// one item per cycle and shows its result in the next cycle: the walker registers step by
// one cell per item and a single output register holds the result, so the input
// is only stalled while that register is full and stalled downstream. Writing
// either register restarts the walk at the first cell; write them only while idle.
module matrix_scan_order_filler_core
  import msof_pkg::*;
#(
  parameter int unsigned MAX_SIDE   = MaxSideDefault,
  parameter int unsigned DATA_WIDTH = DataWidthDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration write port
  input  wire logic                     cfg_we_i,
  input  wire logic [CfgIndexWidth-1:0] cfg_index_i,
  input  wire logic [CfgDataWidth-1:0]  cfg_data_i,
  // input channel
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [DATA_WIDTH-1:0]    in_value_i,
  // output channel
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [CoordWidth-1:0]         out_row_o,
  output logic [CoordWidth-1:0]         out_col_o,
  output logic [DATA_WIDTH-1:0]         out_value_o,
  output logic                          out_last_o
);

  localparam int unsigned SW = $clog2(MAX_SIDE + 1);
  localparam int unsigned CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned DW = SW + 1;
  localparam int unsigned NW = $clog2(MAX_SIDE * MAX_SIDE + 1);

  typedef struct packed {
    logic [CW-1:0] r;
    logic [CW-1:0] c;
    logic [CW-1:0] lo;
    logic [CW-1:0] hi;
  } spiral_pos_t;

  // Clockwise step to the next cell of the spiral
  function automatic spiral_pos_t spiral_fwd(spiral_pos_t p);
    spiral_pos_t q;
    q = p;
    if (p.r == p.lo && p.c < p.hi) begin
      q.c = p.c + 1'b1;
    end else if (p.c == p.hi && p.r < p.hi) begin
      q.r = p.r + 1'b1;
    end else if (p.r == p.hi && p.c > p.lo) begin
      q.c = p.c - 1'b1;
    end else if (p.c == p.lo && p.r > p.lo + 1'b1) begin
      q.r = p.r - 1'b1;
    end else begin
      q.lo = p.lo + 1'b1;
      q.hi = p.hi - 1'b1;
      q.r  = p.lo + 1'b1;
      q.c  = p.lo + 1'b1;
    end
    return q;
  endfunction

  // Step back to the previous cell of the spiral
  function automatic spiral_pos_t spiral_bwd(spiral_pos_t p);
    spiral_pos_t q;
    q = p;
    if (p.r == p.lo && p.c == p.lo) begin
      q.lo = p.lo - 1'b1;
      q.hi = p.hi + 1'b1;
      q.r  = p.lo;
      q.c  = p.lo - 1'b1;
    end else if (p.r == p.lo) begin
      q.c = p.c - 1'b1;
    end else if (p.c == p.hi) begin
      q.r = p.r - 1'b1;
    end else if (p.r == p.hi) begin
      q.c = p.c + 1'b1;
    end else begin
      q.r = p.r + 1'b1;
    end
    return q;
  endfunction

  // Registers
  logic [SideRegWidth-1:0] side_q, side_d;
  logic [ModeRegWidth-1:0] mode_q, mode_d;
  logic                    start_q, start_d;
  logic [NW-1:0]           cnt_q, cnt_d;
  logic [CW-1:0]           drow_q, drow_d, dcol_q, dcol_d;
  logic [DW-1:0]           didx_q, didx_d;
  spiral_pos_t             spos_q, spos_d;
  logic                    out_valid_q, out_valid_d;
  logic [CoordWidth-1:0]   out_row_q, out_row_d, out_col_q, out_col_d;
  logic [DATA_WIDTH-1:0]   out_value_q, out_value_d;
  logic                    out_last_q, out_last_d;

  // Working signals
  logic [SW-1:0]   n_eff;
  logic [CW-1:0]   nm1;
  logic [CW-1:0]   half;
  logic [2*SW-1:0] total_m1;
  logic            in_accept;
  logic            out_take;
  logic [NW-1:0]   cur_cnt;
  logic [CW-1:0]   cur_drow, cur_dcol;
  logic [DW-1:0]   cur_didx;
  logic [DW-1:0]   next_didx;
  logic [DW-1:0]   next_drow_w;
  spiral_pos_t     spos_init, cur_spos, next_spos;
  logic [CW-1:0]   row_sel, col_sel;
  logic            is_last;

  // Effective side: zero reads as one, large values saturate
  always_comb begin
    if (side_q == '0) begin
      n_eff = SW'(1);
    end else if (32'(side_q) > 32'(MAX_SIDE)) begin
      n_eff = SW'(MAX_SIDE);
    end else begin
      n_eff = SW'(side_q);
    end
  end

  assign nm1      = CW'(n_eff - 1'b1);
  assign half     = nm1 >> 1;
  assign total_m1 = (2*SW)'(n_eff) * (2*SW)'(n_eff) - 1'b1;

  // Handshake: one output register, refilled in the cycle it drains
  assign out_take   = out_valid_q && !out_stall_i;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Walk position of the current item, fresh after a restart
  always_comb begin
    spos_init = '0;
    if (mode_q == MODE_SPIRAL_REV) begin
      spos_init.lo = half;
      spos_init.hi = nm1 - half;
      spos_init.r  = nm1 - half;
      spos_init.c  = half;
    end else begin
      spos_init.hi = nm1;
    end
  end

  assign cur_cnt  = start_q ? '0 : cnt_q;
  assign cur_drow = start_q ? '0 : drow_q;
  assign cur_dcol = start_q ? '0 : dcol_q;
  assign cur_didx = start_q ? '0 : didx_q;
  assign cur_spos = start_q ? spos_init : spos_q;

  // Advance the anti-diagonal walker
  assign next_didx   = cur_didx + 1'b1;
  assign next_drow_w = (next_didx > DW'(nm1)) ? next_didx - DW'(nm1) : '0;

  // Advance the spiral walker in the mode's direction
  assign next_spos = (mode_q == MODE_SPIRAL_REV) ? spiral_bwd(cur_spos) : spiral_fwd(cur_spos);

  // Select the cell for the mode
  always_comb begin
    unique case (mode_q)
      MODE_DIAG: begin
        row_sel = cur_drow;
        col_sel = cur_dcol;
      end
      MODE_DIAG_MIRROR: begin
        row_sel = cur_drow;
        col_sel = nm1 - cur_dcol;
      end
      default: begin
        row_sel = cur_spos.r;
        col_sel = cur_spos.c;
      end
    endcase
  end

  assign is_last = ((2*SW)'(cur_cnt) == total_m1);

  // Next state of configuration and walkers
  always_comb begin
    side_d  = side_q;
    mode_d  = mode_q;
    start_d = start_q;
    cnt_d   = cnt_q;
    drow_d  = drow_q;
    dcol_d  = dcol_q;
    didx_d  = didx_q;
    spos_d  = spos_q;
    if (cfg_we_i) begin
      // restart the walk on any register write
      case (cfg_index_i)
        REG_SIDE:      side_d = SideRegWidth'(cfg_data_i);
        REG_SCAN_MODE: mode_d = ModeRegWidth'(cfg_data_i);
        default:       ;
      endcase
      start_d = 1'b1;
    end else if (in_accept) begin
      if (is_last) begin
        start_d = 1'b1;
      end else begin
        start_d = 1'b0;
        cnt_d   = cur_cnt + 1'b1;
        spos_d  = next_spos;
        didx_d  = cur_didx;
        if (cur_drow < nm1 && cur_dcol != '0) begin
          drow_d = cur_drow + 1'b1;
          dcol_d = cur_dcol - 1'b1;
        end else begin
          didx_d = next_didx;
          drow_d = CW'(next_drow_w);
          dcol_d = CW'(next_didx - next_drow_w);
        end
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    if (out_take) begin
      out_valid_d = 1'b0;
    end
    if (in_accept) begin
      out_valid_d = 1'b1;
      out_row_d   = CoordWidth'(row_sel);
      out_col_d   = CoordWidth'(col_sel);
      out_value_d = in_value_i;
      out_last_d  = is_last;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q      <= SideReset;
      mode_q      <= ModeReset;
      start_q     <= 1'b1;
      cnt_q       <= '0;
      drow_q      <= '0;
      dcol_q      <= '0;
      didx_q      <= '0;
      spos_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      side_q      <= side_d;
      mode_q      <= mode_d;
      start_q     <= start_d;
      cnt_q       <= cnt_d;
      drow_q      <= drow_d;
      dcol_q      <= dcol_d;
      didx_q      <= didx_d;
      spos_q      <= spos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    out_row_q   <= out_row_d;
    out_col_q   <= out_col_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire
